@@ design/wzdf_pkg.sv @@
// wzdf_pkg: shared widths, a reset value, the sum ceiling and the position flag struct
// for the weighted zone density feature block. No dependencies.
package wzdf_pkg;

   // fixed field widths
   localparam int PIXEL_W  = 8;
   localparam int SUM_W    = 6;
   localparam int IDX_W    = 8;
   localparam int WEIGHT_W = 3;

   // register reset value and accumulator ceiling
   localparam logic [PIXEL_W-1:0] DARK_THRESHOLD_RESET = 8'd50;
   localparam logic [SUM_W-1:0]   SUM_MAX              = 6'd63;

   // where the pixel in the work stage sits in the image and zone grid
   typedef struct packed {
      logic             first_row;      // row 0, nothing above
      logic             first_col;      // column 0, nothing to the left
      logic             in_zone;        // pixel belongs to a full zone
      logic             col_zone_end;   // last column of its zone
      logic             zone_end;       // bottom-right pixel of its zone
      logic             last_zone;      // zone is the final one of the image
      logic [IDX_W-1:0] zone_index;     // zone row * zones per side + zone column
   } pos_flags_type;

endpackage

@@ design/weighted_zone_density_features.sv @@
// weighted_zone_density_features: top level, input register, work stage and
// result register. Depends on wzdf_pkg, wzdf_pos, wzdf_window, wzdf_zone.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid, req_stall, req_pixel_gray          | in
//  rsp     | rsp_valid, rsp_stall, rsp_zone_weight_sum,    | out
//          | rsp_zone_index, rsp_last_zone                 |
//  csr     | csr_wr_en, csr_wr_data (dark threshold)       | in
//
// One pixel per clock while req_stall is low. A pixel is held in the input
// register, then the work stage updates the line and zone sums; the result
// register takes a zone result as the work stage passes on its last pixel.
// Reset (synchronous) clears counters, line, sums and sets the threshold to 50.
// req_stall rises only when a zone result waits in the work stage while the
// result register is full and stalled.
module weighted_zone_density_features import wzdf_pkg::*; #(
   parameter int IMAGE_SIDE     = 48,
   parameter int ZONES_PER_SIDE = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIXEL_W-1:0] req_pixel_gray,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SUM_W-1:0]   rsp_zone_weight_sum,
   output logic [IDX_W-1:0]   rsp_zone_index,
   output logic               rsp_last_zone,
   input  logic               csr_wr_en,
   input  logic [PIXEL_W-1:0] csr_wr_data
);

   logic [PIXEL_W-1:0]  threshold_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]  gray_ff;
   logic                out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]    out_sum_ff;
   logic [IDX_W-1:0]    out_index_ff;
   logic                out_last_ff;
   pos_flags_type       flags;
   logic [WEIGHT_W-1:0] weight;
   logic [SUM_W-1:0]    zone_sum;
   logic                emit, out_free, advance, accept;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= DARK_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // handshake between input register, work stage and result register
   assign emit      = flags.in_zone && flags.zone_end;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && (!emit || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = (advance && emit) ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gray_ff <= req_pixel_gray;
      end
   end

   // work stage
   wzdf_pos #(
      .IMAGE_SIDE     (IMAGE_SIDE),
      .ZONES_PER_SIDE (ZONES_PER_SIDE)
   ) u_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .flags   (flags)
   );

   wzdf_window #(
      .IMAGE_SIDE (IMAGE_SIDE)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .pixel_gray     (gray_ff),
      .dark_threshold (threshold_ff),
      .flags          (flags),
      .weight         (weight)
   );

   wzdf_zone #(
      .ZONES_PER_SIDE (ZONES_PER_SIDE)
   ) u_zone (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .flags    (flags),
      .weight   (weight),
      .zone_sum (zone_sum)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_sum_ff   <= zone_sum;
         out_index_ff <= flags.zone_index;
         out_last_ff  <= flags.last_zone;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_zone_weight_sum = out_sum_ff;
   assign rsp_zone_index      = out_index_ff;
   assign rsp_last_zone       = out_last_ff;

endmodule

@@ design/wzdf_pos.sv @@
// wzdf_pos: pixel position and zone position counters for the work stage.
// Depends on wzdf_pkg (pos_flags_type, IDX_W).
module wzdf_pos import wzdf_pkg::*; #(
   parameter int IMAGE_SIDE     = 48,
   parameter int ZONES_PER_SIDE = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   output pos_flags_type flags
);

   localparam int ZS        = IMAGE_SIDE / ZONES_PER_SIDE;
   localparam bit HAS_ZONES = (ZS > 0);
   localparam int ZS_LAST   = (ZS > 0) ? ZS - 1 : 0;
   localparam int CW        = $clog2(IMAGE_SIDE);
   localparam int SUBW      = (ZS > 1) ? $clog2(ZS) : 1;
   localparam int ZCW       = $clog2(ZONES_PER_SIDE + 1);

   logic [CW-1:0]   col_ff, col_in, row_ff, row_in;
   logic [SUBW-1:0] col_sub_ff, col_sub_in, row_sub_ff, row_sub_in;
   logic [ZCW-1:0]  zc_ff, zc_in, zr_ff, zr_in;
   logic            col_last, row_last, col_sub_last, row_sub_last;

   assign col_last     = (col_ff == CW'(IMAGE_SIDE - 1));
   assign row_last     = (row_ff == CW'(IMAGE_SIDE - 1));
   assign col_sub_last = (col_sub_ff == SUBW'(ZS_LAST));
   assign row_sub_last = (row_sub_ff == SUBW'(ZS_LAST));

   // next position, raster order with wrap to a new image
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      col_sub_in = col_sub_ff;
      row_sub_in = row_sub_ff;
      zc_in      = zc_ff;
      zr_in      = zr_ff;
      if (col_last) begin
         col_in     = '0;
         col_sub_in = '0;
         zc_in      = '0;
         if (row_last) begin
            row_in     = '0;
            row_sub_in = '0;
            zr_in      = '0;
         end else begin
            row_in = row_ff + 1'b1;
            if (row_sub_last) begin
               row_sub_in = '0;
               if (zr_ff != ZCW'(ZONES_PER_SIDE)) begin
                  zr_in = zr_ff + 1'b1;
               end
            end else begin
               row_sub_in = row_sub_ff + 1'b1;
            end
         end
      end else begin
         col_in = col_ff + 1'b1;
         if (col_sub_last) begin
            col_sub_in = '0;
            if (zc_ff != ZCW'(ZONES_PER_SIDE)) begin
               zc_in = zc_ff + 1'b1;
            end
         end else begin
            col_sub_in = col_sub_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_sub_ff <= '0;
         row_sub_ff <= '0;
         zc_ff      <= '0;
         zr_ff      <= '0;
      end else if (advance) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_sub_ff <= col_sub_in;
         row_sub_ff <= row_sub_in;
         zc_ff      <= zc_in;
         zr_ff      <= zr_in;
      end
   end

   // flags for the pixel now in the work stage
   always_comb begin
      flags.first_row    = (row_ff == '0);
      flags.first_col    = (col_ff == '0);
      flags.in_zone      = HAS_ZONES && (zc_ff != ZCW'(ZONES_PER_SIDE))
                           && (zr_ff != ZCW'(ZONES_PER_SIDE));
      flags.col_zone_end = col_sub_last;
      flags.zone_end     = col_sub_last && row_sub_last;
      flags.last_zone    = (zc_ff == ZCW'(ZONES_PER_SIDE - 1))
                           && (zr_ff == ZCW'(ZONES_PER_SIDE - 1));
      flags.zone_index   = IDX_W'(32'(zr_ff) * ZONES_PER_SIDE + 32'(zc_ff));
   end

endmodule

@@ design/wzdf_window.sv @@
// wzdf_window: dark test, one-row line of dark bits and the 2x2 neighbour weight.
// Depends on wzdf_pkg (widths, pos_flags_type).
module wzdf_window import wzdf_pkg::*; #(
   parameter int IMAGE_SIDE = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [PIXEL_W-1:0]  pixel_gray,
   input  logic [PIXEL_W-1:0]  dark_threshold,
   input  pos_flags_type       flags,
   output logic [WEIGHT_W-1:0] weight
);

   logic [IMAGE_SIDE-1:0] line_ff;
   logic                  left_ff, upleft_ff;
   logic                  dark, up;

   assign dark = (pixel_gray < dark_threshold);
   // oldest tap is the pixel one row up
   assign up   = line_ff[IMAGE_SIDE-1];

   // weight of a dark pixel: itself plus dark neighbours inside the image
   always_comb begin
      weight = '0;
      if (dark) begin
         weight = WEIGHT_W'(1)
                + WEIGHT_W'(left_ff && !flags.first_col)
                + WEIGHT_W'(up && !flags.first_row)
                + WEIGHT_W'(upleft_ff && !flags.first_row && !flags.first_col);
      end
   end

   // slide the neighbourhood by one pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= '0;
         left_ff   <= 1'b0;
         upleft_ff <= 1'b0;
      end else if (advance) begin
         line_ff   <= {line_ff[IMAGE_SIDE-2:0], dark};
         left_ff   <= dark;
         upleft_ff <= up;
      end
   end

endmodule

@@ design/wzdf_zone.sv @@
// wzdf_zone: partial weight sums of one zone row, kept as a rotating line
// with the current zone column at the head. Depends on wzdf_pkg.
module wzdf_zone import wzdf_pkg::*; #(
   parameter int ZONES_PER_SIDE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  pos_flags_type       flags,
   input  logic [WEIGHT_W-1:0] weight,
   output logic [SUM_W-1:0]    zone_sum
);

   logic [SUM_W-1:0] acc_ff [ZONES_PER_SIDE];
   logic [SUM_W:0]   sum_wide;

   // saturating add of this pixel's weight
   assign sum_wide = {1'b0, acc_ff[0]} + (SUM_W+1)'(weight);
   assign zone_sum = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

   // at a zone column boundary the head moves to the tail, cleared when the zone closes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ZONES_PER_SIDE; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (advance && flags.in_zone) begin
         if (flags.col_zone_end) begin
            for (int i = 0; i < ZONES_PER_SIDE - 1; i++) begin
               acc_ff[i] <= acc_ff[i+1];
            end
            acc_ff[ZONES_PER_SIDE-1] <= flags.zone_end ? '0 : zone_sum;
         end else begin
            acc_ff[0] <= zone_sum;
         end
      end
   end

endmodule

@@ design/wzdf_checker.sv @@
// wzdf_checker: port-level checks on the result channel, bound to the top level.
// Depends on wzdf_pkg (widths) and weighted_zone_density_features.
module wzdf_checker import wzdf_pkg::*; #(
   parameter int ZONES_PER_SIDE = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SUM_W-1:0]   rsp_zone_weight_sum,
   input logic [IDX_W-1:0]   rsp_zone_index,
   input logic               rsp_last_zone
);

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(ZONES_PER_SIDE * ZONES_PER_SIDE - 1);

   // a stalled item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a stalled item keeps its fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_zone_weight_sum) && $stable(rsp_zone_index)
                                 && $stable(rsp_last_zone))
      else $error("result item changed while stalled");

   // the final zone carries the last index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_zone |-> rsp_zone_index == LAST_INDEX)
      else $error("final zone flag on wrong zone index");

   // a fresh result follows an item taken at the input, through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result item without a matching input item");

endmodule

bind weighted_zone_density_features wzdf_checker #(
   .ZONES_PER_SIDE (ZONES_PER_SIDE)
) u_wzdf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_zone_weight_sum (rsp_zone_weight_sum),
   .rsp_zone_index      (rsp_zone_index),
   .rsp_last_zone       (rsp_last_zone)
);
